// ----- rtl/rmaa_pkg.sv -----
// Shared constants and helper functions for the rotation matrix to
// axis-angle converter. No dependencies.
`default_nettype none
package rmaa_pkg;

  localparam int IN_FRAC_BITS_DEF  = 30;
  localparam int OUT_FRAC_BITS_DEF = 28;
  localparam int ANG_FRAC          = 30;
  localparam int CORDIC_STEPS      = 31;
  localparam int SQ_STEPS          = 32;
  localparam int NSQ_STEPS         = 31;
  localparam int DIV_STEPS         = 32;
  localparam int CX_W              = 37;
  localparam int CZ_W              = 35;
  localparam logic [63:0] PI_ANG      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_ANG = 64'd1686629713;
  localparam logic [31:0] TINY_ANG    = 32'd11;

  function automatic logic [31:0] atan_tab(int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      default: v = (i < 31) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] out_limit(int to);
    return (PI_ANG >> (ANG_FRAC - to)) + ((PI_ANG >> (ANG_FRAC - to - 1)) & 64'd1);
  endfunction

  function automatic logic [30:0] sat_out(logic [63:0] mag, int from, int to, logic neg);
    logic [63:0] lim;
    logic [63:0] m;
    int k;
    lim = out_limit(to);
    if (to >= from) begin
      k = to - from;
      if (k >= 40 || mag > (lim >> k)) begin
        m = lim;
      end else begin
        m = mag << k;
      end
    end else begin
      k = from - to;
      m = (mag >> k) + ((mag >> (k - 1)) & 64'd1);
    end
    if (m > lim) begin
      m = lim;
    end
    m = neg ? (64'd0 - m) : m;
    return m[30:0];
  endfunction

  function automatic logic signed [31:0] clamp_elem(logic signed [31:0] raw,
                                                    logic signed [31:0] one);
    logic signed [31:0] v;
    if (raw > one) begin
      v = one;
    end else if (raw < -one) begin
      v = -one;
    end else begin
      v = raw;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rotation_matrix_to_axis_angle.sv -----
// Top level: rotation matrix (Q1.IN) to theta-u rotation vector (Q2.OUT).
// Depends on rmaa_pkg, rmaa_delay, rmaa_sqrt_cell, rmaa_div_cell, rmaa_cordic_cell.
//
//   channel  dir  tdata                                   tuser
//   in_      in   rot_00..rot_22, 32 bits each (288)      -
//   out_     out  axis_x, axis_y, axis_z, 31 bits each    near_pi
//
// One beat per cycle unless the output stalls; the depth is set by the chain of square root,
// CORDIC and divider cells (32 + 31 + 32 cells plus surrounding stages).
// Reset clears the valid bits of every stage; no clearing pass.
// A stalled output beat holds the whole chain; in_tready follows it.
`default_nettype none
module rotation_matrix_to_axis_angle #(
  parameter int IN_FRAC_BITS  = rmaa_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = rmaa_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [287:0] in_tdata,   // rot_00, rot_01, .. rot_22
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [95:0]  out_tdata,  // axis_x, axis_y, axis_z, zero fill
  output logic              out_tuser   // near_pi
);
  localparam int CX_W = rmaa_pkg::CX_W;
  localparam int CZ_W = rmaa_pkg::CZ_W;
  localparam int ANG_SH = rmaa_pkg::ANG_FRAC - IN_FRAC_BITS;
  localparam int DEN_SH = rmaa_pkg::ANG_FRAC - OUT_FRAC_BITS;
  localparam int GDEN_W = 32 + DEN_SH;
  localparam logic signed [35:0] ONE = 36'sd1 <<< IN_FRAC_BITS;
  localparam logic signed [35:0] EPS = (ONE + 36'sd5000) / 36'sd10000;
  localparam logic signed [31:0] ONE32 = 32'(ONE);
  localparam logic [63:0] LIM = rmaa_pkg::out_limit(OUT_FRAC_BITS);
  localparam logic signed [30:0] LIM_S = $signed(31'(LIM));

  localparam int ST_SUM = 3;
  localparam int ST_S2  = ST_SUM + rmaa_pkg::SQ_STEPS;
  localparam int ST_PRE = ST_S2 + 1;
  localparam int ST_TH  = ST_PRE + rmaa_pkg::CORDIC_STEPS + 1;
  localparam int ST_NR  = 1 + rmaa_pkg::DIV_STEPS;
  localparam int ST_NQ  = ST_NR + rmaa_pkg::NSQ_STEPS;
  localparam int ST_MUL = ST_TH + 1;
  localparam int ST_RND = ST_MUL + 1;
  localparam int ST_DIV = ST_RND + rmaa_pkg::DIV_STEPS;
  localparam int ST_OUT = ST_DIV + 1;

  logic en;
  logic [ST_OUT:1] vld_r;

  assign en        = !vld_r[ST_OUT] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST_OUT-1:1], in_tvalid};
    end
  end

  // stage 1: clamp, differences, trace, near-pi operands
  logic signed [31:0] m [9];
  logic signed [32:0] d [3];
  logic signed [33:0] t_nxt;
  logic signed [35:0] a_s [3];
  logic signed [35:0] b_s;
  logic [31:0] mag_nxt [3];
  logic [63:0] ndv_nxt [3];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m[k] = rmaa_pkg::clamp_elem($signed(in_tdata[32*k +: 32]), ONE32);
    end
    d[0] = 33'(m[7]) - 33'(m[5]);
    d[1] = 33'(m[2]) - 33'(m[6]);
    d[2] = 33'(m[3]) - 33'(m[1]);
    t_nxt = 34'(m[0]) + 34'(m[4]) + 34'(m[8]);
    b_s = ONE * 36'sd3 - 36'(t_nxt);
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = d[k][32] ? 32'(-d[k]) : 32'(d[k]);
      a_s[k] = (36'(m[4*k]) <<< 1) - 36'(t_nxt) + ONE;
      ndv_nxt[k] = (a_s[k] >= 36'sd2) ? (64'(a_s[k]) << 30) : 64'd0;
    end
  end

  logic [31:0] mag1_r [3];
  logic [2:0]  neg1_r;
  logic signed [33:0] t1_r;
  logic gen1_r;
  logic [63:0] ndv1_r [3];
  logic [32:0] nden1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag1_r[k] <= mag_nxt[k];
        neg1_r[k] <= d[k][32];
        ndv1_r[k] <= ndv_nxt[k];
      end
      t1_r    <= t_nxt;
      gen1_r  <= (36'(t_nxt) + ONE) > (EPS <<< 1);
      nden1_r <= b_s[32:0];
    end
  end

  // stages 2, 3: squares and their sum
  logic [63:0] sq2_r [3];
  logic [63:0] sum3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq2_r[k] <= 64'(mag1_r[k]) * 64'(mag1_r[k]);
      end
      sum3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
    end
  end

  // norm of the antisymmetric part
  logic [63:0] sqv [rmaa_pkg::SQ_STEPS+1];
  logic [63:0] sqr [rmaa_pkg::SQ_STEPS+1];
  assign sqv[0] = sum3_r;
  assign sqr[0] = 64'd0;

  for (genvar j = 0; j < rmaa_pkg::SQ_STEPS; j++) begin : g_sq
    rmaa_sqrt_cell #(.BIT_POS(62 - 2*j)) u_cell (
      .clk(clk), .en(en), .v_i(sqv[j]), .r_i(sqr[j]), .v_o(sqv[j+1]), .r_o(sqr[j+1])
    );
  end

  logic [31:0] s2_35;
  assign s2_35 = sqr[rmaa_pkg::SQ_STEPS][31:0];

  logic [33:0] t35;
  rmaa_delay #(.W(34), .N(ST_S2 - 1)) u_dly_t (
    .clk(clk), .en(en), .d(t1_r), .q(t35)
  );

  // pre-rotation into the right half plane
  logic signed [CX_W-1:0] cx [rmaa_pkg::CORDIC_STEPS+1];
  logic signed [CX_W-1:0] cy [rmaa_pkg::CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] cz [rmaa_pkg::CORDIC_STEPS+1];
  logic signed [CX_W-1:0] px_r, py_r, px_nxt, py_nxt, x0;
  logic signed [CZ_W-1:0] pz_r, pz_nxt;

  always_comb begin
    x0 = (CX_W'($signed(t35)) - CX_W'(ONE)) <<< ANG_SH;
    px_nxt = x0;
    py_nxt = $signed(CX_W'(s2_35)) <<< ANG_SH;
    pz_nxt = '0;
    if (x0 < 0) begin
      px_nxt = $signed(CX_W'(s2_35)) <<< ANG_SH;
      py_nxt = -x0;
      pz_nxt = $signed(CZ_W'(rmaa_pkg::HALF_PI_ANG));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
  end

  assign cx[0] = px_r;
  assign cy[0] = py_r;
  assign cz[0] = pz_r;

  for (genvar i = 0; i < rmaa_pkg::CORDIC_STEPS; i++) begin : g_cor
    rmaa_cordic_cell #(.I(i)) u_cell (
      .clk(clk), .en(en), .x_i(cx[i]), .y_i(cy[i]), .z_i(cz[i]),
      .x_o(cx[i+1]), .y_o(cy[i+1]), .z_o(cz[i+1])
    );
  end

  logic [31:0] theta_r;
  logic signed [CZ_W-1:0] zf;
  assign zf = cz[rmaa_pkg::CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf < 0) begin
        theta_r <= 32'd0;
      end else if (zf > $signed(CZ_W'(rmaa_pkg::PI_ANG))) begin
        theta_r <= 32'(rmaa_pkg::PI_ANG);
      end else begin
        theta_r <= 32'(zf);
      end
    end
  end

  // near-pi ratio and root
  logic [31:0] nq64 [3];
  for (genvar k = 0; k < 3; k++) begin : g_near
    logic [63:0] rem [rmaa_pkg::DIV_STEPS+1];
    logic [32:0] den [rmaa_pkg::DIV_STEPS+1];
    logic [31:0] quo [rmaa_pkg::DIV_STEPS+1];
    logic [63:0] nv  [rmaa_pkg::NSQ_STEPS+1];
    logic [63:0] nr  [rmaa_pkg::NSQ_STEPS+1];
    assign rem[0] = ndv1_r[k];
    assign den[0] = nden1_r;
    assign quo[0] = 32'd0;
    for (genvar j = 0; j < rmaa_pkg::DIV_STEPS; j++) begin : g_div
      rmaa_div_cell #(.NUM_W(64), .DEN_W(33), .J(rmaa_pkg::DIV_STEPS - 1 - j)) u_cell (
        .clk(clk), .en(en), .rem_i(rem[j]), .den_i(den[j]), .q_i(quo[j]),
        .rem_o(rem[j+1]), .den_o(den[j+1]), .q_o(quo[j+1])
      );
    end
    assign nv[0] = 64'(quo[rmaa_pkg::DIV_STEPS]) << 30;
    assign nr[0] = 64'd0;
    for (genvar j = 0; j < rmaa_pkg::NSQ_STEPS; j++) begin : g_sq
      rmaa_sqrt_cell #(.BIT_POS(60 - 2*j)) u_cell (
        .clk(clk), .en(en), .v_i(nv[j]), .r_i(nr[j]), .v_o(nv[j+1]), .r_o(nr[j+1])
      );
    end
    assign nq64[k] = nr[rmaa_pkg::NSQ_STEPS][31:0];
  end

  logic [95:0] nq68;
  rmaa_delay #(.W(96), .N(ST_TH - ST_NQ)) u_dly_q (
    .clk(clk), .en(en), .d({nq64[2], nq64[1], nq64[0]}), .q(nq68)
  );

  // side data to the angle stage
  logic [99:0] sa68;
  logic [31:0] mag68 [3];
  logic [2:0]  neg68;
  logic        gen68;
  rmaa_delay #(.W(100), .N(ST_TH - 1)) u_dly_a (
    .clk(clk), .en(en), .d({gen1_r, neg1_r, mag1_r[2], mag1_r[1], mag1_r[0]}), .q(sa68)
  );
  assign mag68[0] = sa68[31:0];
  assign mag68[1] = sa68[63:32];
  assign mag68[2] = sa68[95:64];
  assign neg68    = sa68[98:96];
  assign gen68    = sa68[99];

  logic [31:0] s2_69;
  rmaa_delay #(.W(32), .N(ST_MUL - ST_S2)) u_dly_s2 (
    .clk(clk), .en(en), .d(s2_35), .q(s2_69)
  );

  // stage 69: products
  logic [63:0] num_r [3];
  logic [63:0] np_r  [3];
  logic [2:0]  neg69_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= 64'(mag68[k]) * 64'(theta_r);
        np_r[k]  <= 64'(theta_r) * 64'(nq68[32*k +: 32]);
      end
      neg69_r <= neg68;
    end
  end

  // stage 70: rounded dividend, near-pi result
  logic [64:0]       gdv_r [3];
  logic [GDEN_W-1:0] gden_r, gden_nxt;
  logic [30:0]       near70_r [3];
  logic              s2z70_r;

  assign gden_nxt = GDEN_W'(s2_69) << DEN_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        gdv_r[k]    <= 65'(num_r[k]) + 65'(gden_nxt >> 1);
        near70_r[k] <= rmaa_pkg::sat_out(np_r[k], 60, OUT_FRAC_BITS, neg69_r[k]);
      end
      gden_r  <= gden_nxt;
      s2z70_r <= (s2_69 == 32'd0);
    end
  end

  // general quotient
  logic [31:0] gq [3];
  for (genvar k = 0; k < 3; k++) begin : g_gen
    logic [64:0]       rem [rmaa_pkg::DIV_STEPS+1];
    logic [GDEN_W-1:0] den [rmaa_pkg::DIV_STEPS+1];
    logic [31:0]       quo [rmaa_pkg::DIV_STEPS+1];
    assign rem[0] = gdv_r[k];
    assign den[0] = gden_r;
    assign quo[0] = 32'd0;
    for (genvar j = 0; j < rmaa_pkg::DIV_STEPS; j++) begin : g_div
      rmaa_div_cell #(.NUM_W(65), .DEN_W(GDEN_W), .J(rmaa_pkg::DIV_STEPS - 1 - j)) u_cell (
        .clk(clk), .en(en), .rem_i(rem[j]), .den_i(den[j]), .q_i(quo[j]),
        .rem_o(rem[j+1]), .den_o(den[j+1]), .q_o(quo[j+1])
      );
    end
    assign gq[k] = quo[rmaa_pkg::DIV_STEPS];
  end

  logic [100:0] sb102;
  logic         tiny68;
  assign tiny68 = theta_r < rmaa_pkg::TINY_ANG;
  rmaa_delay #(.W(101), .N(ST_DIV - ST_TH)) u_dly_b (
    .clk(clk), .en(en), .d({tiny68, sa68}), .q(sb102)
  );

  logic [93:0] sc102;
  rmaa_delay #(.W(94), .N(ST_DIV - ST_RND)) u_dly_c (
    .clk(clk), .en(en), .d({s2z70_r, near70_r[2], near70_r[1], near70_r[0]}), .q(sc102)
  );

  // stage 103: branch select and output register
  logic [30:0] res_nxt [3];
  logic [30:0] res_r   [3];
  logic        near_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!sb102[99]) begin
        res_nxt[k] = sc102[31*k +: 31];
      end else if (sb102[100]) begin
        res_nxt[k] = rmaa_pkg::sat_out(64'(sb102[32*k +: 32]), IN_FRAC_BITS + 1,
                                       OUT_FRAC_BITS, sb102[96+k]);
      end else if (sc102[93]) begin
        res_nxt[k] = 31'd0;
      end else begin
        res_nxt[k] = rmaa_pkg::sat_out(64'(gq[k]), OUT_FRAC_BITS, OUT_FRAC_BITS,
                                       sb102[96+k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        res_r[k] <= res_nxt[k];
      end
      near_r <= !sb102[99];
    end
  end

  assign out_tvalid = vld_r[ST_OUT];
  assign out_tdata  = {3'b000, res_r[2], res_r[1], res_r[0]};
  assign out_tuser  = near_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted beat did not enter the chain");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("chain moved during a stall");

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(res_r[0]) <= LIM_S) && ($signed(res_r[0]) >= -LIM_S)
                && ($signed(res_r[1]) <= LIM_S) && ($signed(res_r[1]) >= -LIM_S)
                && ($signed(res_r[2]) <= LIM_S) && ($signed(res_r[2]) >= -LIM_S))
    else $error("output component beyond pi");
endmodule
`default_nettype wire

// ----- rtl/rmaa_delay.sv -----
// Enable-gated shift line that carries side data along the pipeline.
// No dependencies.
`default_nettype none
module rmaa_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[N-1];
endmodule
`default_nettype wire

// ----- rtl/rmaa_sqrt_cell.sv -----
// One bit of a restoring integer square root, registered.
// No dependencies.
`default_nettype none
module rmaa_sqrt_cell #(
  parameter int BIT_POS = 62
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] v_i,
  input  wire logic [63:0] r_i,
  output logic      [63:0] v_o,
  output logic      [63:0] r_o
);
  localparam logic [63:0] BIT = 64'd1 << BIT_POS;
  logic [63:0] v_r, r_r, v_nxt, r_nxt, trial;

  always_comb begin
    trial = r_i + BIT;
    if (v_i >= trial) begin
      v_nxt = v_i - trial;
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;
endmodule
`default_nettype wire

// ----- rtl/rmaa_div_cell.sv -----
// One quotient bit of a restoring divider, registered; passes the divisor on.
// No dependencies.
`default_nettype none
module rmaa_div_cell #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int J     = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] rem_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [31:0]      q_i,
  output logic      [NUM_W-1:0] rem_o,
  output logic      [DEN_W-1:0] den_o,
  output logic      [31:0]      q_o
);
  localparam int CW = (NUM_W > DEN_W + J) ? NUM_W : DEN_W + J;
  logic [CW-1:0]    rem_x, sub_x;
  logic             fit;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [31:0]      q_r, q_nxt;

  always_comb begin
    rem_x   = CW'(rem_i);
    sub_x   = CW'(den_i) << J;
    fit     = rem_x >= sub_x;
    rem_nxt = fit ? NUM_W'(rem_x - sub_x) : rem_i;
    q_nxt   = q_i | (fit ? (32'd1 << J) : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign q_o   = q_r;
endmodule
`default_nettype wire

// ----- rtl/rmaa_cordic_cell.sv -----
// One vectoring-mode CORDIC micro-rotation, registered.
// Depends on rmaa_pkg for the arctangent table and widths.
`default_nettype none
module rmaa_cordic_cell #(
  parameter int I = 0
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [rmaa_pkg::CX_W-1:0] x_i,
  input  wire logic signed [rmaa_pkg::CX_W-1:0] y_i,
  input  wire logic signed [rmaa_pkg::CZ_W-1:0] z_i,
  output logic      signed [rmaa_pkg::CX_W-1:0] x_o,
  output logic      signed [rmaa_pkg::CX_W-1:0] y_o,
  output logic      signed [rmaa_pkg::CZ_W-1:0] z_o
);
  localparam logic signed [rmaa_pkg::CZ_W-1:0] ANG =
    $signed(rmaa_pkg::CZ_W'(rmaa_pkg::atan_tab(I)));
  logic signed [rmaa_pkg::CX_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [rmaa_pkg::CZ_W-1:0] z_r, z_nxt;

  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> I);
      y_nxt = y_i - (x_i >>> I);
      z_nxt = z_i + ANG;
    end else if (y_i < 0) begin
      x_nxt = x_i - (y_i >>> I);
      y_nxt = y_i + (x_i >>> I);
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule
`default_nettype wire

// ----- sim/rotation_matrix_to_axis_angle_test.sv -----
// Self-checking bench for rotation_matrix_to_axis_angle: directed and random matrices,
// predicted in-bench and compared beat by beat. Depends on the RTL top and, through it, rmaa_pkg.
`timescale 1ns / 100ps
`default_nettype none
module rotation_matrix_to_axis_angle_test;

  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint EPS_Q30 = (ONE_Q30 + 5000) / 10000;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TINY_Q30 = 11;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [30:0] axis_x;
    logic [30:0] axis_y;
    logic [30:0] axis_z;
    logic near_pi;
  } axis_angle_t;

  class axis_angle_scoreboard;
    axis_angle_t pending_q[$];
    int errors;
    int beats_seen;
    int near_pi_seen;

    static function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    static function automatic longint unsigned round_shift(longint unsigned m, int k);
      if (k == 0) return m;
      return (m >> k) + ((m >> (k - 1)) & 64'd1);
    endfunction

    static function automatic longint unsigned atan_step(int i);
      case (i)
        0: return 843314857;
        1: return 497837829;
        2: return 263043837;
        3: return 133525159;
        4: return 67021687;
        5: return 33543516;
        6: return 16775851;
        7: return 8388437;
        8: return 4194283;
        9: return 2097149;
        default: return 64'd1 << (30 - i);
      endcase
    endfunction

    static function automatic longint vector_angle(longint x, longint y);
      longint z, xn, yn, tmp;
      z = 0;
      if (x < 0) begin
        tmp = x;
        x = y;
        y = -tmp;
        z = HALF_PI_Q30;
      end
      for (int i = 0; i < 31; i++) begin
        xn = x;
        yn = y;
        if (y > 0) begin
          xn = x + (y >>> i);
          yn = y - (x >>> i);
          z = z + longint'(atan_step(i));
        end else if (y < 0) begin
          xn = x - (y >>> i);
          yn = y + (x >>> i);
          z = z - longint'(atan_step(i));
        end
        x = xn;
        y = yn;
      end
      if (z < 0) z = 0;
      if (z > PI_Q30) z = PI_Q30;
      return z;
    endfunction

    static function automatic logic [30:0] to_q28(longint unsigned mag, int from, bit neg);
      longint unsigned lim;
      lim = round_shift(PI_Q30, 2);
      if (from <= 28) begin
        if (mag > (lim >> (28 - from))) mag = lim;
        else mag = mag << (28 - from);
      end else begin
        mag = round_shift(mag, from - 28);
      end
      if (mag > lim) mag = lim;
      if (neg) mag = 64'd0 - mag;
      return mag[30:0];
    endfunction

    static function automatic axis_angle_t predict(logic [287:0] raw);
      longint m[9];
      longint d[3];
      longint t, theta, a, b;
      longint unsigned sum, s2, mag, num, den, r, q;
      logic [30:0] comp[3];
      bit general, neg;
      axis_angle_t res;
      for (int k = 0; k < 9; k++) begin
        m[k] = longint'($signed(raw[k*32 +: 32]));
        if (m[k] > ONE_Q30) m[k] = ONE_Q30;
        if (m[k] < -ONE_Q30) m[k] = -ONE_Q30;
      end
      d[0] = m[7] - m[5];
      d[1] = m[2] - m[6];
      d[2] = m[3] - m[1];
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        mag = (d[k] < 0) ? -d[k] : d[k];
        sum = sum + mag * mag;
      end
      s2 = int_sqrt(sum);
      t = m[0] + m[4] + m[8];
      theta = vector_angle(t - ONE_Q30, longint'(s2));
      general = (t + ONE_Q30) > 2 * EPS_Q30;
      for (int k = 0; k < 3; k++) begin
        mag = (d[k] < 0) ? -d[k] : d[k];
        neg = d[k] < 0;
        if (general) begin
          if (theta < TINY_Q30) begin
            comp[k] = to_q28(mag, 31, neg);
          end else if (s2 == 0) begin
            comp[k] = '0;
          end else begin
            num = mag * longint'(theta);
            den = s2 << 2;
            comp[k] = to_q28((num + den / 2) / den, 28, neg);
          end
        end else begin
          a = 2 * m[k*4] - t + ONE_Q30;
          b = 3 * ONE_Q30 - t;
          if (a < 2 || b <= 0) begin
            comp[k] = '0;
          end else begin
            r = (longint'(a) << 30) / b;
            q = int_sqrt(r << 30);
            comp[k] = to_q28(longint'(theta) * q, 60, neg);
          end
        end
      end
      res.axis_x = comp[0];
      res.axis_y = comp[1];
      res.axis_z = comp[2];
      res.near_pi = !general;
      return res;
    endfunction

    function void note_matrix(logic [287:0] raw);
      pending_q = {pending_q, predict(raw)};
    endfunction

    function void check_beat(logic [95:0] data, logic user);
      axis_angle_t exp_r;
      beats_seen++;
      if (user) near_pi_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected output beat tdata=%h tuser=%b", data, user);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (data[30:0] !== exp_r.axis_x) begin
        $error("axis_x expected %h actual %h", exp_r.axis_x, data[30:0]);
        errors++;
      end
      if (data[61:31] !== exp_r.axis_y) begin
        $error("axis_y expected %h actual %h", exp_r.axis_y, data[61:31]);
        errors++;
      end
      if (data[92:62] !== exp_r.axis_z) begin
        $error("axis_z expected %h actual %h", exp_r.axis_z, data[92:62]);
        errors++;
      end
      if (data[95:93] !== 3'b000) begin
        $error("fill expected 0 actual %b", data[95:93]);
        errors++;
      end
      if (user !== exp_r.near_pi) begin
        $error("near_pi expected %b actual %b", exp_r.near_pi, user);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [287:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic out_tuser;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  axis_angle_scoreboard sb;

  always #1 clk = ~clk;

  rotation_matrix_to_axis_angle i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial sb = new();

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_matrix(in_tdata);
      if (out_tvalid && out_tready) sb.check_beat(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] to_q30(real v);
    return $rtoi(v * 1073741824.0 + ((v >= 0.0) ? 0.5 : -0.5));
  endfunction

  function automatic real rand_unit();
    return ($urandom_range(2000000) / 1000000.0) - 1.0;
  endfunction

  function automatic logic [287:0] rotation(real ux, real uy, real uz, real ang, int noise);
    real n, c, s, v, e[9];
    logic [287:0] raw;
    n = $sqrt(ux * ux + uy * uy + uz * uz);
    if (n < 1.0e-3) begin
      ux = 0.0;
      uy = 0.0;
      uz = 1.0;
      n = 1.0;
    end
    ux = ux / n;
    uy = uy / n;
    uz = uz / n;
    c = $cos(ang);
    s = $sin(ang);
    v = 1.0 - c;
    e[0] = c + ux * ux * v;
    e[1] = ux * uy * v - uz * s;
    e[2] = ux * uz * v + uy * s;
    e[3] = uy * ux * v + uz * s;
    e[4] = c + uy * uy * v;
    e[5] = uy * uz * v - ux * s;
    e[6] = uz * ux * v - uy * s;
    e[7] = uz * uy * v + ux * s;
    e[8] = c + uz * uz * v;
    for (int k = 0; k < 9; k++) begin
      raw[k*32 +: 32] = to_q30(e[k]);
      if (noise > 0) raw[k*32 +: 32] = raw[k*32 +: 32] + $urandom_range(2 * noise) - noise;
    end
    return raw;
  endfunction

  task automatic send_matrix(logic [287:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_matrix();
    logic [287:0] raw;
    int pick;
    real ang;
    pick = $urandom_range(99);
    if (pick < 15) begin
      for (int k = 0; k < 9; k++) raw[k*32 +: 32] = $urandom();
    end else if (pick < 25) begin
      for (int k = 0; k < 9; k++) raw[k*32 +: 32] = to_q30(rand_unit() * 1.1);
    end else begin
      case ($urandom_range(3))
        0: ang = 3.14159265358979 - $urandom_range(20000) / 1000000.0;
        1: ang = $urandom_range(1000) * 1.0e-9;
        default: ang = $urandom_range(3141592) / 1000000.0;
      endcase
      raw = rotation(rand_unit(), rand_unit(), rand_unit(), ang,
                     ($urandom_range(3) == 0) ? $urandom_range(64) : 0);
    end
    send_matrix(raw);
  endtask

  initial begin
    logic [287:0] raw;
    int p_idle[4] = '{0, 75, 0, 10};
    int p_stall[4] = '{0, 0, 75, 10};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, identity, zero, half-turns, tiny and near-half-turn angles
    send_matrix({9{32'h4000_0000}});
    send_matrix({9{32'hC000_0000}});
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'hFFFF_FFFF}});
    send_matrix('0);
    send_matrix({288{1'b1}} ^ {9{32'h5555_5555}});
    send_matrix({9{32'h5555_5555}});
    send_matrix(rotation(0.0, 0.0, 1.0, 0.0, 0));
    send_matrix(rotation(1.0, 0.0, 0.0, 3.14159265358979, 0));
    send_matrix(rotation(0.0, 1.0, 0.0, 3.14159265358979, 0));
    send_matrix(rotation(0.0, 0.0, 1.0, 3.14159265358979, 0));
    send_matrix(rotation(1.0, -1.0, 1.0, 3.14159265358979, 0));
    send_matrix(rotation(-1.0, 2.0, 0.5, 3.1415, 0));
    send_matrix(rotation(0.3, -0.2, 0.9, 3.1216, 0));
    send_matrix(rotation(0.3, -0.2, 0.9, 3.1200, 0));
    send_matrix(rotation(0.6, 0.0, -0.8, 5.0e-9, 0));
    send_matrix(rotation(0.6, 0.0, -0.8, 1.0e-8, 0));
    send_matrix(rotation(0.6, 0.0, -0.8, 2.0e-8, 0));
    send_matrix(rotation(-0.5, 0.5, 0.7, 1.5707963, 0));
    send_matrix(rotation(0.1, 0.9, -0.4, 2.5, 40));
    raw = '0;
    raw[0 +: 32] = 32'h4000_0000;
    raw[128 +: 32] = 32'hC000_0000;
    raw[256 +: 32] = 32'hC000_0000;
    raw[32 +: 32] = 32'h0000_0100;
    send_matrix(raw);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = p_idle[ph];
      stall_pct = p_stall[ph];
      repeat (120) send_random_matrix();
    end
    in_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d result beats (%0d near a half turn) across four idle/stall mixes",
             sb.beats_seen, sb.near_pi_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
